// ===== sv/rsa_pkg.sv =====
package rsa_pkg;

    localparam int PRIME_BITS = 16;
    localparam int WORD_BITS  = 32;
    localparam int CNT_BITS   = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 2;
    localparam int TDATA_OUT_BITS = ((1 + 4 * WORD_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_P  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_Q  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PUB_EXP  = 2'd2;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    // modular multiplier request and response
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } mm_rsp_t;

    // divider request and response
    typedef struct packed {
        logic  start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t quo;
        word_t rem;
    } div_rsp_t;

    // (x + y) mod m for x, y below m
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

endpackage

// ===== sv/textbook_rsa_key_and_modexp_core.sv =====
// sequence: with an invalid cached key, an input transfer goes straight through S_NMUL
// to S_OUT and m_tvalid; otherwise the modulus reduction is followed by two
// exponentiations on the bit-serial modular multiplier; a key derivation after a
// register write first runs extended-euclid steps, each a divide and a modular multiply
// throughput: one message at a time, s_tready is low while a message is in work
// reset: synchronous active-low aresetn; p=2, q=3, e=0, key cache empty
module textbook_rsa_key_and_modexp_core (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // message
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // status, modulus_n, private_exponent,
                                    // cipher_text, recovered_text, zero pad
);
    import rsa_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PHI   = 5'd1;
    localparam logic [4:0] S_ECHK  = 5'd2;
    localparam logic [4:0] S_EDIV  = 5'd3;
    localparam logic [4:0] S_EDIVW = 5'd4;
    localparam logic [4:0] S_EMUL  = 5'd5;
    localparam logic [4:0] S_EMULW = 5'd6;
    localparam logic [4:0] S_EFIN  = 5'd7;
    localparam logic [4:0] S_NMUL  = 5'd8;
    localparam logic [4:0] S_MRED  = 5'd9;
    localparam logic [4:0] S_MREDW = 5'd10;
    localparam logic [4:0] S_PTEST = 5'd11;
    localparam logic [4:0] S_PMUL  = 5'd12;
    localparam logic [4:0] S_PMULW = 5'd13;
    localparam logic [4:0] S_PSQ   = 5'd14;
    localparam logic [4:0] S_PSQW  = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]            state_reg;
    logic [PRIME_BITS-1:0] p_reg;
    logic [PRIME_BITS-1:0] q_reg;
    word_t                 e_reg;
    word_t                 d_reg;
    logic                  status_reg;
    logic                  kvalid_reg;
    logic                  pass_reg;
    logic                  m_tvalid_reg;

    word_t phi_reg, n_reg, msg_reg;
    word_t r0_reg, r1_reg, t0_reg, t1_reg;
    word_t acc_reg, base_reg, exp_reg, cip_reg, rec_reg;
    logic [TDATA_OUT_BITS-1:0] out_reg;

    mm_req_t  mm_req;
    mm_rsp_t  mm_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [PRIME_BITS-1:0]   mul_a;
    logic [PRIME_BITS-1:0]   mul_b;
    logic [2*PRIME_BITS-1:0] prod;
    word_t                   t_new;
    logic                    out_load;

    rsa_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    rsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // shared narrow multiplier for phi and n
    assign mul_a = (state_reg == S_PHI) ? p_reg - 1'b1 : p_reg;
    assign mul_b = (state_reg == S_PHI) ? q_reg - 1'b1 : q_reg;
    assign prod  = mul_a * mul_b;

    // next coefficient (t0 - quo*t1) mod phi
    assign t_new = (t0_reg >= mm_rsp.result) ? t0_reg - mm_rsp.result
                                             : t0_reg + (phi_reg - mm_rsp.result);

    // unit requests
    always_comb begin
        mm_req       = '0;
        div_req      = '0;
        div_req.num  = msg_reg;
        div_req.den  = n_reg;
        mm_req.m     = n_reg;
        mm_req.a     = acc_reg;
        mm_req.b     = base_reg;
        case (state_reg)
            S_EDIV: begin
                div_req.start = 1'b1;
                div_req.num   = r0_reg;
                div_req.den   = r1_reg;
            end
            S_EMUL: begin
                mm_req.start = 1'b1;
                mm_req.a     = div_rsp.quo;
                mm_req.b     = t1_reg;
                mm_req.m     = phi_reg;
            end
            S_MRED:  div_req.start = 1'b1;
            S_PMUL:  mm_req.start  = 1'b1;
            S_PSQ: begin
                mm_req.start = 1'b1;
                mm_req.a     = base_reg;
            end
            default: ;
        endcase
    end

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer, configuration and key cache
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            p_reg        <= PRIME_BITS'(2);
            q_reg        <= PRIME_BITS'(3);
            e_reg        <= '0;
            d_reg        <= '0;
            status_reg   <= STATUS_OK;
            kvalid_reg   <= 1'b0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: set on a load, cleared by a transfer
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= kvalid_reg ? S_NMUL : S_PHI;
                    end
                end
                S_PHI: begin
                    status_reg <= STATUS_INVALID;
                    d_reg      <= '0;
                    if (p_reg < PRIME_BITS'(2) || q_reg < PRIME_BITS'(2)) begin
                        kvalid_reg <= 1'b1;
                        state_reg  <= S_NMUL;
                    end else begin
                        state_reg <= S_ECHK;
                    end
                end
                S_ECHK: begin
                    if (e_reg <= word_t'(1) || e_reg >= phi_reg) begin
                        kvalid_reg <= 1'b1;
                        state_reg  <= S_NMUL;
                    end else begin
                        state_reg <= S_EDIV;
                    end
                end
                S_EDIV:  state_reg <= S_EDIVW;
                S_EDIVW: if (div_rsp.done) state_reg <= S_EMUL;
                S_EMUL:  state_reg <= S_EMULW;
                S_EMULW: begin
                    if (mm_rsp.done) begin
                        state_reg <= (div_rsp.rem == '0) ? S_EFIN : S_EDIV;
                    end
                end
                S_EFIN: begin
                    kvalid_reg <= 1'b1;
                    if (r0_reg == word_t'(1)) begin
                        status_reg <= STATUS_OK;
                        d_reg      <= t0_reg;
                    end
                    state_reg <= S_NMUL;
                end
                S_NMUL: begin
                    pass_reg  <= 1'b0;
                    state_reg <= (status_reg == STATUS_INVALID) ? S_OUT : S_MRED;
                end
                S_MRED:  state_reg <= S_MREDW;
                S_MREDW: if (div_rsp.done) state_reg <= S_PTEST;
                S_PTEST: begin
                    if (exp_reg == '0) begin
                        if (!pass_reg) begin
                            pass_reg <= 1'b1;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= exp_reg[0] ? S_PMUL : S_PSQ;
                    end
                end
                S_PMUL:  state_reg <= S_PMULW;
                S_PMULW: if (mm_rsp.done) state_reg <= S_PSQ;
                S_PSQ:   state_reg <= S_PSQW;
                S_PSQW:  if (mm_rsp.done) state_reg <= S_PTEST;
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // register writes are for the user to make only while idle; the block does not enforce it
            if (cfg_we) begin
                case (cfg_index)
                    REG_PRIME_P: begin
                        p_reg      <= cfg_wdata[PRIME_BITS-1:0];
                        kvalid_reg <= 1'b0;
                    end
                    REG_PRIME_Q: begin
                        q_reg      <= cfg_wdata[PRIME_BITS-1:0];
                        kvalid_reg <= 1'b0;
                    end
                    REG_PUB_EXP: begin
                        e_reg      <= cfg_wdata;
                        kvalid_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: msg_reg <= s_tdata;
            S_PHI:  phi_reg <= word_t'(prod);
            S_ECHK: begin
                r0_reg <= phi_reg;
                r1_reg <= e_reg;
                t0_reg <= '0;
                t1_reg <= word_t'(1);
            end
            S_EMULW: begin
                if (mm_rsp.done) begin
                    r0_reg <= r1_reg;
                    r1_reg <= div_rsp.rem;
                    t0_reg <= t1_reg;
                    t1_reg <= t_new;
                end
            end
            S_NMUL: begin
                n_reg   <= word_t'(prod);
                cip_reg <= '0;
                rec_reg <= '0;
            end
            S_MREDW: begin
                if (div_rsp.done) begin
                    base_reg <= div_rsp.rem;
                    acc_reg  <= word_t'(1);
                    exp_reg  <= e_reg;
                end
            end
            S_PTEST: begin
                if (exp_reg == '0) begin
                    if (!pass_reg) begin
                        cip_reg  <= acc_reg;
                        base_reg <= acc_reg;
                        acc_reg  <= word_t'(1);
                        exp_reg  <= d_reg;
                    end else begin
                        rec_reg <= acc_reg;
                    end
                end
            end
            S_PMULW: if (mm_rsp.done) acc_reg <= mm_rsp.result;
            S_PSQW: begin
                if (mm_rsp.done) begin
                    base_reg <= mm_rsp.result;
                    exp_reg  <= exp_reg >> 1;
                end
            end
            default: ;
        endcase
        // result register
        if (out_load) begin
            out_reg <= {(TDATA_OUT_BITS - 1 - 4 * WORD_BITS)'(0), rec_reg, cip_reg, d_reg,
                        (status_reg == STATUS_INVALID) ? word_t'(0) : n_reg, status_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // an invalid key result carries all-zero values
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[128:1] == '0)
        else $error("invalid key result with nonzero values");

    // a valid cipher lies below the modulus
    a_cipher_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[96:65] < m_tdata[32:1])
        else $error("cipher not reduced");

    // arithmetic units are quiet while the sequencer idles
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !mm_rsp.busy && !div_rsp.busy)
        else $error("unit busy while idle");

endmodule

// ===== sv/rsa_mulmod.sv =====
module rsa_mulmod (
    input  logic             aclk,
    input  logic             aresetn,
    input  rsa_pkg::mm_req_t req,
    output rsa_pkg::mm_rsp_t rsp
);
    import rsa_pkg::*;

    logic  busy_reg;
    logic  done_reg;
    word_t acc_reg;
    word_t a_reg;
    word_t b_reg;
    word_t m_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && b_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // shift and add, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
        end else if (busy_reg && b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= add_mod(acc_reg, a_reg, m_reg);
            end
            a_reg <= add_mod(a_reg, a_reg, m_reg);
            b_reg <= b_reg >> 1;
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== sv/rsa_div.sv =====
module rsa_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsa_pkg::div_req_t req,
    output rsa_pkg::div_rsp_t rsp
);
    import rsa_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    word_t               quo_reg;
    word_t               rem_reg;
    word_t               den_reg;
    logic [WORD_BITS:0]  trial;

    assign trial = {rem_reg, quo_reg[WORD_BITS-1]};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= WORD_BITS'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= trial[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
